### hw/rtl/ssc_pkg.sv
// Shared types and constants for the segment sort and coalesce block.
// Used by ssc_front, ssc_back, the top level and the checker.
`default_nettype none

package ssc_pkg;

   localparam int READ_W  = 31;
   localparam int EDGE_W  = 16;
   localparam int SUPER_W = 31;
   localparam int LEN_W   = 16;
   // Largest index width and count width the store depth may need (depth <= 64).
   localparam int ADDR_MAX_W = 6;
   localparam int CNT_MAX_W  = 7;
   // Full-width folded length: up to 64 lengths of 16 bits.
   localparam int ACC_W = 22;
   localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

   typedef struct packed {
      logic [READ_W-1:0]  read_id;
      logic [EDGE_W-1:0]  edge_start;
      logic [SUPER_W-1:0] super_start;
      logic [LEN_W-1:0]   seg_length;
   } entry_type;

   // store write from the loader
   typedef struct packed {
      logic                  we;
      logic [ADDR_MAX_W-1:0] addr;
      entry_type             data;
   } wr_type;

   // set descriptor handed from loader to sorter
   typedef struct packed {
      logic                 valid;
      logic [CNT_MAX_W-1:0] count;
      logic                 overflow;
   } desc_type;

endpackage

`default_nettype wire

### hw/rtl/ssc_front.sv
// Loader: accepts segments, writes them to the store, counts the set and
// posts a set descriptor to the back end. Depends on ssc_pkg.
`default_nettype none

module ssc_front import ssc_pkg::*; #(
   parameter int MAX_ENTRIES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [READ_W-1:0]  req_read_id,
   input  wire logic [EDGE_W-1:0]  req_edge_start,
   input  wire logic [SUPER_W-1:0] req_super_start,
   input  wire logic [LEN_W-1:0]   req_seg_length,
   input  wire logic               req_last_in,
   input  wire logic               back_busy,
   input  wire logic               desc_take,
   output wr_type                  wr,
   output desc_type                desc
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   desc_type         desc_ff, desc_in;
   logic             xfer, full;

   assign req_stall = desc_ff.valid | back_busy;
   assign xfer      = req_valid & ~req_stall;
   assign full      = (count_ff == CNT_W'(MAX_ENTRIES));

   always_comb begin
      wr.we   = xfer & ~full;
      wr.addr = ADDR_MAX_W'(count_ff);
      wr.data = '{read_id: req_read_id, edge_start: req_edge_start,
                  super_start: req_super_start, seg_length: req_seg_length};
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      desc_in  = desc_ff;
      if (desc_take) begin
         desc_in.valid = 1'b0;
      end
      if (xfer) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
         if (req_last_in) begin
            desc_in.valid    = 1'b1;
            desc_in.count    = CNT_MAX_W'(count_in);
            desc_in.overflow = ovf_in;
            count_in         = '0;
            ovf_in           = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         desc_ff  <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         desc_ff  <= desc_in;
      end
   end

   assign desc = desc_ff;

endmodule

`default_nettype wire

### hw/rtl/ssc_back.sv
// Back end: holds the segment store, insertion-sorts a set in place, then
// walks it once to drop duplicates and fold continuing segments. Uses ssc_pkg.
`default_nettype none

module ssc_back import ssc_pkg::*; #(
   parameter int MAX_ENTRIES = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire wr_type              wr,
   input  wire desc_type            desc,
   output logic                     desc_take,
   output logic                     back_busy,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [READ_W-1:0]        rsp_out_read,
   output logic [EDGE_W-1:0]        rsp_out_edge_start,
   output logic [SUPER_W-1:0]       rsp_out_super_start,
   output logic [LEN_W-1:0]         rsp_out_length,
   output logic                     rsp_length_saturated,
   output logic                     rsp_entries_dropped,
   output logic                     rsp_last_out
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [3:0] {
      IDLE, SORT_I, KEY_RD, KEY_GET, CMP_RD, CMP, PLACE, C_RD, C_USE, C_FINAL
   } state_type;

   state_type         state_ff;
   entry_type         mem [MAX_ENTRIES];
   entry_type         rdata_ff, key_ff, prev_ff;
   logic [IDX_W-1:0]  addr_ff, j_ff;
   logic [CNT_W-1:0]  i_ff, n_ff;
   logic              ovf_ff;
   logic [READ_W-1:0]  cur_read_ff;
   logic [EDGE_W-1:0]  cur_edge_ff;
   logic [SUPER_W-1:0] cur_super_ff;
   logic [ACC_W-1:0]   cur_len_ff;
   logic               rsp_valid_ff;
   logic [READ_W-1:0]  out_read_ff;
   logic [EDGE_W-1:0]  out_edge_ff;
   logic [SUPER_W-1:0] out_super_ff;
   logic [LEN_W-1:0]   out_len_ff;
   logic               out_sat_ff, out_drop_ff, out_last_ff;

   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   entry_type        mem_wd;
   logic             greater, dup, join_ok, slot_free, first, last_idx;
   logic             emit_mid, emit_last;
   logic [ACC_W:0]   edge_sum;
   logic [SUPER_W:0] super_sum;

   assign back_busy = (state_ff != IDLE);
   assign desc_take = desc.valid & (state_ff == IDLE);
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;

   assign greater   = (rdata_ff > key_ff);
   assign first     = (i_ff == '0);
   assign last_idx  = ((i_ff + 1'b1) == n_ff);
   assign dup       = ~first & (rdata_ff == prev_ff);
   assign edge_sum  = (ACC_W+1)'(cur_edge_ff) + (ACC_W+1)'(cur_len_ff);
   assign super_sum = (SUPER_W+1)'(cur_super_ff) + (SUPER_W+1)'(cur_len_ff);
   assign join_ok   = (rdata_ff.read_id == cur_read_ff)
                    & ((ACC_W+1)'(rdata_ff.edge_start) == edge_sum)
                    & ((SUPER_W+1)'(rdata_ff.super_start) == super_sum);

   // a finished segment goes out mid-walk, or the held one at the end of the set
   assign emit_mid  = (state_ff == C_USE) & ~first & ~dup & ~join_ok & slot_free;
   assign emit_last = (state_ff == C_FINAL) & slot_free;

   always_comb begin
      mem_we = 1'b0;
      mem_wa = j_ff;
      mem_wd = key_ff;
      case (state_ff)
         IDLE: begin
            mem_we = wr.we;
            mem_wa = wr.addr[IDX_W-1:0];
            mem_wd = wr.data;
         end
         CMP: begin
            mem_we = greater;
            mem_wd = rdata_ff;
         end
         PLACE: mem_we = 1'b1;
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_mid | emit_last) begin
            rsp_valid_ff <= 1'b1;
         end else if (slot_free) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (desc.valid) begin
                  n_ff     <= desc.count[CNT_W-1:0];
                  ovf_ff   <= desc.overflow;
                  i_ff     <= CNT_W'(1);
                  state_ff <= SORT_I;
               end
            end
            SORT_I: begin
               if (i_ff >= n_ff) begin
                  i_ff     <= '0;
                  addr_ff  <= '0;
                  state_ff <= C_RD;
               end else begin
                  addr_ff  <= i_ff[IDX_W-1:0];
                  state_ff <= KEY_RD;
               end
            end
            KEY_RD: state_ff <= KEY_GET;
            KEY_GET: begin
               key_ff   <= rdata_ff;
               j_ff     <= i_ff[IDX_W-1:0];
               addr_ff  <= i_ff[IDX_W-1:0] - 1'b1;
               state_ff <= CMP_RD;
            end
            CMP_RD: state_ff <= CMP;
            CMP: begin
               // shift the larger entry up one slot and keep scanning down
               if (greater) begin
                  j_ff <= j_ff - 1'b1;
                  if (j_ff == IDX_W'(1)) begin
                     state_ff <= PLACE;
                  end else begin
                     addr_ff  <= j_ff - IDX_W'(2);
                     state_ff <= CMP_RD;
                  end
               end else begin
                  state_ff <= PLACE;
               end
            end
            PLACE: begin
               i_ff     <= i_ff + 1'b1;
               state_ff <= SORT_I;
            end
            C_RD: state_ff <= C_USE;
            C_USE: begin
               if (first || dup || join_ok || slot_free) begin
                  prev_ff <= rdata_ff;
                  if (first || (!dup && !join_ok)) begin
                     if (!first) begin
                        out_read_ff  <= cur_read_ff;
                        out_edge_ff  <= cur_edge_ff;
                        out_super_ff <= cur_super_ff;
                        out_len_ff   <= (cur_len_ff > ACC_W'(LEN_SAT)) ?
                                        LEN_SAT : cur_len_ff[LEN_W-1:0];
                        out_sat_ff   <= (cur_len_ff > ACC_W'(LEN_SAT));
                        out_drop_ff  <= ovf_ff;
                        out_last_ff  <= 1'b0;
                     end
                     cur_read_ff  <= rdata_ff.read_id;
                     cur_edge_ff  <= rdata_ff.edge_start;
                     cur_super_ff <= rdata_ff.super_start;
                     cur_len_ff   <= ACC_W'(rdata_ff.seg_length);
                  end else if (!dup) begin
                     cur_len_ff <= cur_len_ff + ACC_W'(rdata_ff.seg_length);
                  end
                  i_ff <= i_ff + 1'b1;
                  if (last_idx) begin
                     state_ff <= C_FINAL;
                  end else begin
                     addr_ff  <= addr_ff + 1'b1;
                     state_ff <= C_RD;
                  end
               end
            end
            C_FINAL: begin
               if (slot_free) begin
                  out_read_ff  <= cur_read_ff;
                  out_edge_ff  <= cur_edge_ff;
                  out_super_ff <= cur_super_ff;
                  out_len_ff   <= (cur_len_ff > ACC_W'(LEN_SAT)) ?
                                  LEN_SAT : cur_len_ff[LEN_W-1:0];
                  out_sat_ff   <= (cur_len_ff > ACC_W'(LEN_SAT));
                  out_drop_ff  <= ovf_ff;
                  out_last_ff  <= 1'b1;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_read         = out_read_ff;
   assign rsp_out_edge_start   = out_edge_ff;
   assign rsp_out_super_start  = out_super_ff;
   assign rsp_out_length       = out_len_ff;
   assign rsp_length_saturated = out_sat_ff;
   assign rsp_entries_dropped  = out_drop_ff;
   assign rsp_last_out         = out_last_ff;

endmodule

`default_nettype wire

### hw/rtl/segment_sort_and_coalesce.sv
// Segment sort and coalesce, top level: loader, descriptor hand-off, sorter.
// Loading takes one segment per cycle while req_stall is low. After the last
// one, the sorter does an in-place insertion sort on the single store port,
// then a coalesce walk over the sorted entries.
// Results leave through an output register.
// Reset (synchronous) clears the loader counters and control; the store is not cleared.
`default_nettype none

module segment_sort_and_coalesce import ssc_pkg::*; #(
   parameter int MAX_ENTRIES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [READ_W-1:0]  req_read_id,
   input  wire logic [EDGE_W-1:0]  req_edge_start,
   input  wire logic [SUPER_W-1:0] req_super_start,
   input  wire logic [LEN_W-1:0]   req_seg_length,
   input  wire logic               req_last_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [READ_W-1:0]       rsp_out_read,
   output logic [EDGE_W-1:0]       rsp_out_edge_start,
   output logic [SUPER_W-1:0]      rsp_out_super_start,
   output logic [LEN_W-1:0]        rsp_out_length,
   output logic                    rsp_length_saturated,
   output logic                    rsp_entries_dropped,
   output logic                    rsp_last_out
);

   wr_type   wr;
   desc_type desc;
   logic     back_busy, desc_take;

   ssc_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_read_id, .req_edge_start,
      .req_super_start, .req_seg_length, .req_last_in,
      .back_busy, .desc_take, .wr, .desc
   );

   ssc_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
      .clock, .reset, .wr, .desc, .desc_take, .back_busy,
      .rsp_valid, .rsp_stall, .rsp_out_read, .rsp_out_edge_start,
      .rsp_out_super_start, .rsp_out_length, .rsp_length_saturated,
      .rsp_entries_dropped, .rsp_last_out
   );

endmodule

`default_nettype wire

### hw/rtl/ssc_checker.sv
// Port-level checks for segment_sort_and_coalesce, bound to the top level.
// Depends on ssc_pkg.
`default_nettype none

module ssc_checker import ssc_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             req_last_in,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [LEN_W-1:0] rsp_out_length,
   input wire logic             rsp_length_saturated,
   input wire logic             rsp_entries_dropped,
   input wire logic             rsp_last_out
);

   // a result that is held stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // no loading while a finished set is being sorted
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_in |=> req_stall)
      else $error("input taken right after last transfer");

   a_sat_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_saturated |-> rsp_out_length == LEN_SAT)
      else $error("saturated flag without clamped length");

   // drop flag is one value for the whole set
   a_drop_const: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_out |=> $stable(rsp_entries_dropped))
      else $error("entries_dropped changed within a set");

endmodule

bind segment_sort_and_coalesce ssc_checker u_ssc_checker (
   .clock, .reset, .req_valid, .req_stall, .req_last_in, .rsp_valid, .rsp_stall,
   .rsp_out_length, .rsp_length_saturated, .rsp_entries_dropped, .rsp_last_out
);

`default_nettype wire
